@@ sv/double_ended_priority_queue_assert.svh @@
// Assertion macros for the double-ended priority queue checker.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define DEPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define DEPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/depq_pkg.sv @@
// Package with types and codes of the double-ended priority queue.
`timescale 1ns / 1ps
package depq_pkg;
    localparam logic [1:0] KIND_INSERT     = 2'd0;
    localparam logic [1:0] KIND_REMOVE_MAX = 2'd1;
    localparam logic [1:0] KIND_REMOVE_MIN = 2'd2;
    localparam logic [1:0] KIND_CLEAR      = 2'd3;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } depq_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               is_empty;
        logic signed [31:0] largest;
        logic signed [31:0] smallest;
    } depq_out_t;
endpackage

@@ sv/double_ended_priority_queue.sv @@
// Top level of the double-ended priority queue over signed 32-bit values.
//
// Usage:
//   Command channel: present cmd and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy rises on the
//   next cycle and stays high until the result has been shown.
//   Result channel: rslt is valid for exactly one cycle while done is high.
//   The receiver cannot stall; it must take the result in that cycle.
// Storage: one single-port-style RAM of CAPACITY words kept sorted
//   ascending in its first count entries, plus registered copies of the two
//   ends. An insert shifts the tail one word up, one read and one write per
//   step, walking down from the top until the insert slot is found.
// Operations: an insert shifts the tail up until its slot is found, which may
//   be slot zero; remove-smallest shifts the whole body down; remove-largest,
//   clear and a dropped insert do no shifting. Done comes in the cycle after
//   the last step.
// Back to back: busy also covers the done cycle, so the next transaction is
//   taken in the cycle after done at the earliest.
// Reset: count clears, the store reads as empty. RAM contents are not reset.
`timescale 1ns / 1ps
module double_ended_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  depq_pkg::depq_in_t  cmd,
    output logic                busy,
    output logic                done,
    output depq_pkg::depq_out_t rslt
);
    import depq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_IREAD = 3'd1;
    localparam logic [2:0] ST_ICMP  = 3'd2;
    localparam logic [2:0] ST_DREAD = 3'd3;
    localparam logic [2:0] ST_DMOV  = 3'd4;
    localparam logic [2:0] ST_ENDS  = 3'd5;
    localparam logic [2:0] ST_ENDW  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic signed [31:0] key_reg, key_next;
    logic [1:0]         status_reg, status_next;

    // Result strobe, registered after the last read lands.
    logic done_reg;

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            key_reg    <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            key_reg    <= key_next;
            status_reg <= status_next;
        end
    end

    // Ends of the store, captured after the operation.
    logic signed [31:0] max_reg, max_next, min_reg, min_next;

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        min_reg <= min_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        status_next = status_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = key_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Hold off while the previous result is still on show.
                if (start && !done_reg)
                begin
                    key_next    = cmd.value;
                    status_next = STATUS_DONE;
                    idx_next    = count_reg;
                    unique case (cmd.kind)
                        KIND_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_ENDS;
                            end
                            else
                            begin
                                state_next = ST_IREAD;
                            end
                        end
                        KIND_REMOVE_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            state_next = ST_ENDS;
                        end
                        KIND_REMOVE_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_ENDS;
                            end
                            else
                            begin
                                idx_next   = CW'(1);
                                state_next = ST_DREAD;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_ENDS;
                        end
                        default:
                        begin
                            state_next = ST_ENDS;
                        end
                    endcase
                end
            end
            ST_IREAD:
            begin
                // idx is the free slot; read the word just below it.
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_ENDS;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg - 1'b1);
                    state_next = ST_ICMP;
                end
            end
            ST_ICMP:
            begin
                wr_en = 1'b1;
                if (rd_data_reg > key_reg)
                begin
                    // Move the larger word up one slot and keep walking.
                    wr_data    = rd_data_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_IREAD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_ENDS;
                end
            end
            ST_DREAD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_ENDS;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DMOV;
                end
            end
            ST_DMOV:
            begin
                // Shift the word one slot down.
                wr_en      = 1'b1;
                wr_addr    = AW'(idx_reg - 1'b1);
                wr_data    = rd_data_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_DREAD;
            end
            ST_ENDS:
            begin
                // Fetch the largest word; smallest follows.
                rd_en      = 1'b1;
                rd_addr    = AW'(count_reg - 1'b1);
                state_next = ST_ENDW;
            end
            ST_ENDW:
            begin
                max_next   = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                min_next   = rd_data_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_DONE);
        end
    end

    assign busy          = (state_reg != ST_IDLE) || done_reg;
    assign done          = done_reg;
    assign rslt.status   = status_reg;
    assign rslt.is_empty = (count_reg == '0);
    assign rslt.largest  = (count_reg == '0) ? 32'sd0 : max_reg;
    assign rslt.smallest = (count_reg == '0) ? 32'sd0 : min_reg;
endmodule

@@ sv/depq_checker.sv @@
// Port-level checker for the double-ended priority queue, with its bind.
`timescale 1ns / 1ps
`include "double_ended_priority_queue_assert.svh"
module depq_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input depq_pkg::depq_out_t rslt
);
    import depq_pkg::*;

    `DEPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy must follow a command")
    `DEPQ_ASSERT_IMPL(a_done_busy, done, busy, "result shown while not busy")
    `DEPQ_ASSERT_NEXT(a_done_pulse, done, !done, "done held over two cycles")
    `DEPQ_ASSERT_IMPL(a_empty_zero, done && rslt.is_empty, rslt.largest == 0 && rslt.smallest == 0, "nonzero ends")
    `DEPQ_ASSERT_IMPL(a_order, done && !rslt.is_empty, rslt.smallest <= rslt.largest, "bad order")
endmodule

bind double_ended_priority_queue depq_port_checker u_depq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rslt  (rslt)
);
